[src/svpwm_pkg.sv]
package svpwm_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int DUTY_BITS  = 16;
  localparam int QTR_ENTRIES = 256;    // one quadrant of the 1024-entry turn
  localparam int QSIN_W = 17;          // unsigned quarter-wave value, up to 1.0 in Q16
  localparam int TRIG_W = 18;          // signed sine or cosine
  localparam int PROD_W = 35;          // magnitude times sine or cosine
  localparam int XY_W   = 53;          // alpha and sqrt3*beta, scaled by 2^32
  localparam int DIV_W  = 52;          // dividend magnitude and quotient width
  localparam int VDC2_W = 17;
  localparam int REM_W  = 18;
  localparam int TOFF_W = 55;
  localparam int D2_W   = 57;
  localparam int PIPE_LAT = DIV_W + 7; // start edge to the edge that takes the result

  localparam logic [17:0] SQRT3_Q16   = 18'd113512;
  localparam logic [15:0] DC_BUS_RESET = 16'd24000;
  localparam logic        REG_DC_BUS  = 1'b0;

  typedef logic [QSIN_W-1:0] qsin_t [QTR_ENTRIES];

  function automatic longint unsigned sin_series(input longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    x2 = (x * x) >> 30;
    t = (64'd1 << 30) - (x2 / 110);
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 72;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
    return (x * t) >> 30;
  endfunction

  // r is the position within the quadrant in Q30 of a quarter turn.
  function automatic logic [QSIN_W-1:0] sin_quarter(input longint unsigned r);
    longint unsigned s;
    longint unsigned v;
    s = sin_series((r * 64'd1686629713) >> 30);
    v = (s + (64'd1 << 13)) >> 14;
    return v[QSIN_W-1:0];
  endfunction

  function automatic qsin_t build_qsin();
    qsin_t tab;
    for (int j = 0; j < QTR_ENTRIES; j++) begin
      tab[j] = sin_quarter(longint'(j) << 22);
    end
    return tab;
  endfunction

  localparam qsin_t QSIN = build_qsin();
  localparam logic [QSIN_W-1:0] QSIN_TOP = sin_quarter(64'd1 << 30);

  // Table sine at a 10-bit index over one full turn.
  function automatic logic signed [TRIG_W-1:0] table_sin(input logic [9:0] idx);
    logic [QSIN_W-1:0] mag;
    logic [7:0] j;
    j = idx[7:0];
    if (!idx[8]) begin
      mag = QSIN[j];
    end else if (j == 8'd0) begin
      mag = QSIN_TOP;
    end else begin
      mag = QSIN[8'(~j + 8'd1)];
    end
    if (idx[9]) begin
      return -$signed({1'b0, mag});
    end
    return $signed({1'b0, mag});
  endfunction

  // Edge vector m at m*60 degrees: 2*sqrt3*sin and 2*cos of its angle.
  function automatic logic signed [2:0] edge_sin2r3(input logic [2:0] m);
    case (m)
      3'd1, 3'd2: return 3'sd3;
      3'd4, 3'd5: return -3'sd3;
      default:    return 3'sd0;
    endcase
  endfunction

  function automatic logic signed [2:0] edge_cos2(input logic [2:0] m);
    case (m)
      3'd0:       return 3'sd2;
      3'd1, 3'd5: return 3'sd1;
      3'd2, 3'd4: return -3'sd1;
      default:    return -3'sd2;
    endcase
  endfunction

  // Switch state of edge vector m: bit 2 is U, bit 1 is V, bit 0 is W.
  function automatic logic [2:0] edge_sw(input logic [2:0] m);
    case (m)
      3'd0:    return 3'd4;
      3'd1:    return 3'd6;
      3'd2:    return 3'd2;
      3'd3:    return 3'd3;
      3'd4:    return 3'd1;
      default: return 3'd5;
    endcase
  endfunction

  function automatic logic [2:0] next_sector(input logic [2:0] s);
    return (s == 3'd5) ? 3'd0 : 3'(s + 3'd1);
  endfunction

  function automatic logic [DUTY_BITS-1:0] duty_out(input logic signed [D2_W-1:0] d2);
    logic [33:0] sum;
    logic [16:0] r;
    if (d2 <= 0) begin
      return '0;
    end
    if (d2 >= (D2_W'(1) <<< 33)) begin
      return '1;
    end
    sum = d2[33:0] + 34'(1 << 16);
    r = sum[33:17];
    if (r[16]) begin
      return '1;
    end
    return r[15:0];
  endfunction

endpackage

[src/svpwm_duty_calculator.sv]
// Space-vector PWM duty calculator for a two-level three-phase inverter. An item
// (magnitude and angle) is taken on any cycle with start_i high; busy_o never
// rises, so one item per clock is sustained. Each result is driven with done_o
// high for exactly one cycle, once its item has passed the front stages, the
// divider and the back stages, and is taken by the edge that ends that cycle. The
// receiver cannot stall the block and must take every result in that one cycle.
// Most of the latency is a 52-stage restoring divider that turns the two
// active-vector times into fractions of the period, one quotient bit per stage.
// dc_bus_voltage sits at byte address 0 of the APB port and must only be
// written while no item is in flight.
module svpwm_duty_calculator import svpwm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] ref_magnitude_i,
  input  logic [15:0] ref_angle_i,
  output logic        done_o,
  output logic [15:0] duty_u_o,
  output logic [15:0] duty_v_o,
  output logic [15:0] duty_w_o,
  output logic [2:0]  sector_o,
  output logic        overmodulated_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] dc_q;
  logic [VDC2_W-1:0] vdc2;

  assign pready = 1'b1;
  assign busy_o = 1'b0;
  assign prdata = (paddr[2] == REG_DC_BUS) ? {16'd0, dc_q} : 32'd0;
  assign vdc2   = {((dc_q == 16'd0) ? 16'd1 : dc_q), 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_q <= DC_BUS_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_DC_BUS) begin
      dc_q <= pwdata[15:0];
    end
  end

  // Front stages: sector and table indexes, table read, products, scaling, edge-vector projections.
  logic v0_q, v1_q, v2_q, v3_q, v4_q;
  logic [15:0] vm0_q, vm1_q, ang0_q;
  logic [2:0] sec0_q, sec1_q, sec2_q, sec3_q, sec4_q;
  logic signed [TRIG_W-1:0] sin1_q, cos1_q;
  logic signed [PROD_W-1:0] ps2_q, pc2_q;
  logic signed [XY_W-1:0] xs3_q, ys3_q;
  logic [18:0] ang6;
  logic [15:0] ang_cos;
  logic [2:0] kl3;
  logic signed [55:0] pl_full, pr_full;
  logic [DIV_W-1:0] pl_mag, pr_mag;
  logic [DIV_W-1:0] na4_q, nb4_q;
  logic nega4_q, negb4_q;

  assign ang6    = {1'b0, ref_angle_i, 2'd0} + {2'd0, ref_angle_i, 1'b0};
  assign ang_cos = ang0_q + 16'd16384;
  assign kl3     = next_sector(sec3_q);
  assign pl_full = $signed(xs3_q) * $signed(edge_sin2r3(kl3))
                 - $signed(ys3_q) * $signed(edge_cos2(kl3));
  assign pr_full = $signed(xs3_q) * $signed(edge_sin2r3(sec3_q))
                 - $signed(ys3_q) * $signed(edge_cos2(sec3_q));
  assign pl_mag  = pl_full[55] ? DIV_W'(-pl_full) : pl_full[DIV_W-1:0];
  assign pr_mag  = pr_full[55] ? DIV_W'(-pr_full) : pr_full[DIV_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v0_q <= start_i && !busy_o;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    vm0_q   <= ref_magnitude_i;
    ang0_q  <= ref_angle_i;
    sec0_q  <= ang6[18:16];
    vm1_q   <= vm0_q;
    sin1_q  <= table_sin(ang0_q[15:6]);
    cos1_q  <= table_sin(ang_cos[15:6]);
    sec1_q  <= sec0_q;
    pc2_q   <= $signed({1'b0, vm1_q}) * cos1_q;
    ps2_q   <= $signed({1'b0, vm1_q}) * sin1_q;
    sec2_q  <= sec1_q;
    xs3_q   <= XY_W'(pc2_q) <<< 16;
    ys3_q   <= XY_W'(ps2_q) * $signed(XY_W'(SQRT3_Q16));
    sec3_q  <= sec2_q;
    na4_q   <= pl_mag;
    nb4_q   <= pr_mag;
    nega4_q <= pl_full[55];
    negb4_q <= pr_full[55];
    sec4_q  <= sec3_q;
  end

  // Restoring divider: each stage shifts in one dividend bit and one quotient bit.
  logic             dv_q   [DIV_W];
  logic [DIV_W-1:0] dna_q  [DIV_W];
  logic [DIV_W-1:0] dnb_q  [DIV_W];
  logic [REM_W-1:0] dra_q  [DIV_W];
  logic [REM_W-1:0] drb_q  [DIV_W];
  logic             dsa_q  [DIV_W];
  logic             dsb_q  [DIV_W];
  logic [2:0]       dsec_q [DIV_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_W; k++) begin
        dv_q[k] <= 1'b0;
      end
    end else begin
      dv_q[0] <= v4_q;
      for (int k = 1; k < DIV_W; k++) begin
        dv_q[k] <= dv_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic [DIV_W-1:0] na, nb;
    logic [REM_W-1:0] ra, rb, ta_r, tb_r;
    for (int k = 0; k < DIV_W; k++) begin
      if (k == 0) begin
        na = na4_q;
        nb = nb4_q;
        ra = '0;
        rb = '0;
        dsa_q[k]  <= nega4_q;
        dsb_q[k]  <= negb4_q;
        dsec_q[k] <= sec4_q;
      end else begin
        na = dna_q[k-1];
        nb = dnb_q[k-1];
        ra = dra_q[k-1];
        rb = drb_q[k-1];
        dsa_q[k]  <= dsa_q[k-1];
        dsb_q[k]  <= dsb_q[k-1];
        dsec_q[k] <= dsec_q[k-1];
      end
      ta_r = {ra[REM_W-2:0], na[DIV_W-1]};
      tb_r = {rb[REM_W-2:0], nb[DIV_W-1]};
      if (ta_r >= {1'b0, vdc2}) begin
        dra_q[k] <= ta_r - {1'b0, vdc2};
        dna_q[k] <= {na[DIV_W-2:0], 1'b1};
      end else begin
        dra_q[k] <= ta_r;
        dna_q[k] <= {na[DIV_W-2:0], 1'b0};
      end
      if (tb_r >= {1'b0, vdc2}) begin
        drb_q[k] <= tb_r - {1'b0, vdc2};
        dnb_q[k] <= {nb[DIV_W-2:0], 1'b1};
      end else begin
        drb_q[k] <= tb_r;
        dnb_q[k] <= {nb[DIV_W-2:0], 1'b0};
      end
    end
  end

  // Back stages: signed times and zero time, then the three duties.
  logic v5_q, done_q;
  logic signed [XY_W-1:0] ta5_q, tb5_q;
  logic signed [TOFF_W-1:0] toff5_q;
  logic [2:0] sec5_q;
  logic signed [XY_W-1:0] ta_d, tb_d;
  logic [DUTY_BITS-1:0] duty_d [3];
  logic [2:0] swr, swl;

  assign ta_d = dsa_q[DIV_W-1] ? -$signed({1'b0, dna_q[DIV_W-1]})
                               : $signed({1'b0, dna_q[DIV_W-1]});
  assign tb_d = dsb_q[DIV_W-1] ? $signed({1'b0, dnb_q[DIV_W-1]})
                               : -$signed({1'b0, dnb_q[DIV_W-1]});
  assign swr  = edge_sw(sec5_q);
  assign swl  = edge_sw(next_sector(sec5_q));

  always_comb begin
    logic signed [D2_W-1:0] d2;
    for (int p = 0; p < 3; p++) begin
      d2 = D2_W'(toff5_q);
      if (swr[2-p]) begin
        d2 = d2 + (D2_W'(ta5_q) <<< 1);
      end
      if (swl[2-p]) begin
        d2 = d2 + (D2_W'(tb5_q) <<< 1);
      end
      duty_d[p] = duty_out(d2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v5_q   <= dv_q[DIV_W-1];
      done_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ta5_q   <= ta_d;
    tb5_q   <= tb_d;
    toff5_q <= (TOFF_W'(1) <<< 32) - TOFF_W'(ta_d) - TOFF_W'(tb_d);
    sec5_q  <= dsec_q[DIV_W-1];
    duty_u_o        <= duty_d[0];
    duty_v_o        <= duty_d[1];
    duty_w_o        <= duty_d[2];
    sector_o        <= sec5_q;
    overmodulated_o <= toff5_q[TOFF_W-1];
  end

  assign done_o = done_q;

endmodule

[src/svpwm_checker.sv]
module svpwm_checker import svpwm_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       done_o,
  input logic [2:0] sector_o,
  input logic       pready
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, PIPE_LAT))
    else $error("result without a matching item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> sector_o <= 3'd5)
    else $error("sector out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o && pready)
    else $error("block stalled a port");

endmodule

bind svpwm_duty_calculator svpwm_checker u_svpwm_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .done_o   (done_o),
  .sector_o (sector_o),
  .pready   (pready)
);
